>>> design/bad_pkg.sv
package bad_pkg;

    // fixed field widths
    localparam int SAMPLE_BITS = 16;
    localparam int SPAN_BITS   = 11;
    localparam int AVG_BITS    = 24;
    localparam int FRAC_BITS   = 8;

    localparam logic [SPAN_BITS-1:0] SPAN_RESET = 11'd8;

    typedef enum logic [0:0] {
        OP_SAMPLE = 1'b0,
        OP_FLUSH  = 1'b1
    } opcode_t;

    typedef struct packed {
        opcode_t                 opcode;
        logic [SAMPLE_BITS-1:0]  sample_value;
    } in_item_t;

    typedef struct packed {
        logic [AVG_BITS-1:0] average_value;
        logic                is_partial;
    } out_item_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } div_state_t;

endpackage

>>> design/block_average_decimator.sv
// channel  | handshake          | payload
// item     | push / full        | in_item_t  (opcode, sample_value)
// result   | empty / pop        | out_item_t (average_value, is_partial)
// config   | cfg_we             | cfg_wdata  (span_length)
//
// samples are taken one a cycle while full is low; each group result goes through the
// bit-serial divider and is then loaded into the output register for hand-off
// two finished groups queue ahead of the divider; when both wait, full rises
// a result waits in the output register while the divider works the next group
// reset clears the accumulator, queue and divider; span_length resets to 8
module block_average_decimator
    import bad_pkg::*;
#(
    parameter int MAX_SPAN = 1024
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  in_item_t             item,
    output logic                 empty,
    input  logic                 pop,
    output out_item_t            result,
    input  logic                 cfg_we,
    input  logic [SPAN_BITS-1:0] cfg_wdata
);

    localparam int CNT_BITS = $clog2(MAX_SPAN + 1);
    localparam int SUM_BITS = SAMPLE_BITS + CNT_BITS;
    localparam int JOB_W    = SUM_BITS + CNT_BITS + 1;

    logic                job_push, job_pop, job_full, job_empty;
    logic [SUM_BITS-1:0] f_sum, b_sum;
    logic [CNT_BITS-1:0] f_div, b_div;
    logic                f_partial, b_partial;
    logic [JOB_W-1:0]    job_wdata, job_rdata;

    assign full = job_full;

    // front: accumulate and classify
    bad_front #(
        .MAX_SPAN (MAX_SPAN),
        .CNT_BITS (CNT_BITS),
        .SUM_BITS (SUM_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .item        (item),
        .full        (job_full),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .job_push    (job_push),
        .job_sum     (f_sum),
        .job_div     (f_div),
        .job_partial (f_partial)
    );

    // group queue between the two halves
    assign job_wdata = {f_sum, f_div, f_partial};
    assign {b_sum, b_div, b_partial} = job_rdata;

    bad_fifo #(
        .WIDTH (JOB_W)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .wdata (job_wdata),
        .full  (job_full),
        .pop   (job_pop),
        .rdata (job_rdata),
        .empty (job_empty)
    );

    // back: divide and present
    bad_divider #(
        .CNT_BITS (CNT_BITS),
        .SUM_BITS (SUM_BITS)
    ) u_divider (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_empty   (job_empty),
        .job_pop     (job_pop),
        .job_sum     (b_sum),
        .job_div     (b_div),
        .job_partial (b_partial),
        .empty       (empty),
        .pop         (pop),
        .result      (result)
    );

endmodule

>>> design/bad_front.sv
module bad_front
    import bad_pkg::*;
#(
    parameter int MAX_SPAN = 1024,
    parameter int CNT_BITS = 11,
    parameter int SUM_BITS = 27
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  in_item_t             item,
    input  logic                 full,
    input  logic                 cfg_we,
    input  logic [SPAN_BITS-1:0] cfg_wdata,
    output logic                 job_push,
    output logic [SUM_BITS-1:0]  job_sum,
    output logic [CNT_BITS-1:0]  job_div,
    output logic                 job_partial
);

    logic [SPAN_BITS-1:0] span_reg;
    logic [SUM_BITS-1:0]  sum_reg, sum_next;
    logic [CNT_BITS-1:0]  count_reg, count_next;

    logic                 accept;
    logic [31:0]          span_wide;
    logic [CNT_BITS-1:0]  span_eff;
    logic [SUM_BITS-1:0]  sum_add;
    logic [CNT_BITS-1:0]  count_inc;

    // span in force: zero reads as one, large values saturate
    always_comb
    begin
        span_wide = 32'(span_reg);
        if (span_reg == '0)
        begin
            span_wide = 32'd1;
        end
        else if (span_wide > 32'(MAX_SPAN))
        begin
            span_wide = 32'(MAX_SPAN);
        end
        span_eff = span_wide[CNT_BITS-1:0];
    end

    assign accept    = push && !full;
    assign sum_add   = sum_reg + {{(SUM_BITS-SAMPLE_BITS){item.sample_value[SAMPLE_BITS-1]}},
                                  item.sample_value};
    assign count_inc = count_reg + 1'b1;

    // classify the beat and hand finished groups to the queue
    always_comb
    begin
        sum_next    = sum_reg;
        count_next  = count_reg;
        job_push    = 1'b0;
        job_sum     = sum_add;
        job_div     = span_eff;
        job_partial = 1'b0;
        if (accept)
        begin
            unique case (item.opcode)
                OP_FLUSH:
                begin
                    job_push    = (sum_reg != '0);
                    job_sum     = sum_reg;
                    job_div     = count_reg;
                    job_partial = 1'b1;
                    sum_next    = '0;
                    count_next  = '0;
                end
                OP_SAMPLE:
                begin
                    if (count_inc >= span_eff)
                    begin
                        job_push   = 1'b1;
                        sum_next   = '0;
                        count_next = '0;
                    end
                    else
                    begin
                        sum_next   = sum_add;
                        count_next = count_inc;
                    end
                end
                default:
                begin
                    sum_next   = sum_reg;
                    count_next = count_reg;
                end
            endcase
        end
    end

    // span register and accumulator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span_reg  <= SPAN_RESET;
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                span_reg <= cfg_wdata;
            end
            sum_reg   <= sum_next;
            count_reg <= count_next;
        end
    end

endmodule

>>> design/bad_fifo.sv
module bad_fifo
#(
    parameter int WIDTH = 39
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[rd_ptr_reg];

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

>>> design/bad_divider.sv
module bad_divider
    import bad_pkg::*;
#(
    parameter int CNT_BITS = 11,
    parameter int SUM_BITS = 27
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_empty,
    output logic                job_pop,
    input  logic [SUM_BITS-1:0] job_sum,
    input  logic [CNT_BITS-1:0] job_div,
    input  logic                job_partial,
    output logic                empty,
    input  logic                pop,
    output out_item_t           result
);

    localparam int DW   = SUM_BITS + FRAC_BITS;
    localparam int CNTW = $clog2(DW);

    div_state_t          state_reg, state_next;
    logic                out_valid_reg;
    out_item_t           result_reg;

    logic [DW-1:0]       quo_reg;
    logic [CNT_BITS-1:0] rem_reg;
    logic [CNT_BITS-1:0] div_reg;
    logic [CNTW-1:0]     step_reg;
    logic                neg_reg;
    logic                partial_reg;

    logic                out_load;
    logic [DW-1:0]       scaled;
    logic [DW-1:0]       magnitude;
    logic [CNT_BITS:0]   rem_shift;
    logic [CNT_BITS+1:0] diff;
    logic [DW-1:0]       quo_signed;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        job_pop    = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            DIV_IDLE:
            begin
                if (!job_empty)
                begin
                    job_pop    = 1'b1;
                    state_next = DIV_RUN;
                end
            end
            DIV_RUN:
            begin
                if (step_reg == '0)
                begin
                    state_next = DIV_DONE;
                end
            end
            DIV_DONE:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_load   = 1'b1;
                    state_next = DIV_IDLE;
                end
            end
            default:
            begin
                state_next = DIV_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= DIV_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // scale by 256 and take the magnitude
    assign scaled    = {job_sum, {FRAC_BITS{1'b0}}};
    assign magnitude = job_sum[SUM_BITS-1] ? (~scaled + 1'b1) : scaled;

    // one restoring step a cycle
    assign rem_shift  = {rem_reg, quo_reg[DW-1]};
    assign diff       = {1'b0, rem_shift} - {2'b00, div_reg};
    assign quo_signed = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            quo_reg     <= magnitude;
            rem_reg     <= '0;
            div_reg     <= job_div;
            neg_reg     <= job_sum[SUM_BITS-1];
            partial_reg <= job_partial;
            step_reg    <= CNTW'(DW - 1);
        end
        else if (state_reg == DIV_RUN)
        begin
            quo_reg  <= {quo_reg[DW-2:0], !diff[CNT_BITS+1]};
            rem_reg  <= diff[CNT_BITS+1] ? rem_shift[CNT_BITS-1:0] : diff[CNT_BITS-1:0];
            step_reg <= step_reg - 1'b1;
        end
        if (out_load)
        begin
            result_reg.average_value <= quo_signed[AVG_BITS-1:0];
            result_reg.is_partial    <= partial_reg;
        end
    end

    assign empty  = !out_valid_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |-> job_div != '0)
        else $error("divider started with a zero divisor");

    a_run_exit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == DIV_RUN |=> state_reg == DIV_RUN || state_reg == DIV_DONE)
        else $error("divider left the run state early");

    a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == DIV_DONE && (!out_valid_reg || pop)) |=> out_valid_reg)
        else $error("finished quotient not shown on the result port");
`endif

endmodule

>>> test/tb_block_average_decimator.sv
`timescale 1ns / 1ps

module tb_block_average_decimator;
    import bad_pkg::*;

    localparam int MAX_SPAN      = 1024;
    localparam int SETTLE_CYCLES = 100;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 4000;
    localparam int PHASE_ITEMS   = 56;

    // tracks group sums and the averages still owed by the block
    class average_board;
        logic [SPAN_BITS-1:0] span_reg;
        longint               group_sum;
        int                   group_count;
        out_item_t            awaited_averages[$];
        int                   errors;

        function new();
            span_reg    = SPAN_RESET;
            group_sum   = 0;
            group_count = 0;
            errors      = 0;
        endfunction

        function void write_span(logic [SPAN_BITS-1:0] value);
            span_reg = value;
        endfunction

        // zero acts as one, anything past the maximum saturates
        function int span_in_force();
            if (span_reg == 0)
                return 1;
            if (span_reg > MAX_SPAN)
                return MAX_SPAN;
            return span_reg;
        endfunction

        // fixed point average with 8 fraction bits, truncated toward zero
        function out_item_t predicted_average(longint sum, int divisor, logic partial);
            longint    scaled;
            out_item_t avg;
            if (divisor == 0)
                divisor = 1;
            scaled            = (sum * 256) / divisor;
            avg.average_value = scaled[AVG_BITS-1:0];
            avg.is_partial    = partial;
            return avg;
        endfunction

        function void note_accepted(in_item_t beat);
            int      span;
            shortint sample;
            span = span_in_force();
            if (beat.opcode == OP_FLUSH)
            begin
                if (group_sum != 0)
                    awaited_averages.push_back(predicted_average(group_sum, group_count, 1'b1));
                group_sum   = 0;
                group_count = 0;
            end
            else
            begin
                sample      = beat.sample_value;
                group_sum   = group_sum + sample;
                group_count = group_count + 1;
                if (group_count >= span)
                begin
                    awaited_averages.push_back(predicted_average(group_sum, span, 1'b0));
                    group_sum   = 0;
                    group_count = 0;
                end
            end
        endfunction

        function void check_average(out_item_t got);
            out_item_t want;
            if (awaited_averages.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected average: expected none, actual %h partial %b",
                         $time, got.average_value, got.is_partial);
                return;
            end
            want = awaited_averages.pop_front();
            if (got.average_value !== want.average_value)
            begin
                errors++;
                $display("%0t: average_value: expected %h, actual %h",
                         $time, want.average_value, got.average_value);
            end
            if (got.is_partial !== want.is_partial)
            begin
                errors++;
                $display("%0t: is_partial: expected %b, actual %b",
                         $time, want.is_partial, got.is_partial);
            end
        endfunction

        function int pending();
            return awaited_averages.size();
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 push;
    logic                 full;
    in_item_t             item;
    logic                 empty;
    logic                 pop;
    out_item_t            result;
    logic                 cfg_we;
    logic [SPAN_BITS-1:0] cfg_wdata;

    average_board board = new();

    int sender_idle_pct;
    int receiver_stall_pct;
    int hold_epoch;
    int idle_cycles;

    block_average_decimator #(
        .MAX_SPAN (MAX_SPAN)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog on cycles with no beat on either side
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("block_average_decimator: mismatch");
                $finish;
            end
        end
    end

    // result side: check each popped beat, stall at random or hold off on request
    initial
    begin : receiver
        int seen_epoch;
        int hold_left;
        seen_epoch = 0;
        hold_left  = 0;
        pop <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
                board.check_average(result);
            if (hold_epoch != seen_epoch)
            begin
                seen_epoch = hold_epoch;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // offer one beat, with random idle cycles ahead of it
    task automatic send_item(input in_item_t beat);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        item <= beat;
        do
            @(posedge clk);
        while (full);
        board.note_accepted(beat);
    endtask

    task automatic send_sample(input logic [SAMPLE_BITS-1:0] value);
        in_item_t beat;
        beat.opcode       = OP_SAMPLE;
        beat.sample_value = value;
        send_item(beat);
    endtask

    task automatic send_flush();
        in_item_t beat;
        beat.opcode       = OP_FLUSH;
        beat.sample_value = SAMPLE_BITS'($urandom);
        send_item(beat);
    endtask

    // stop offering, wait for every owed average, then let the divider settle
    task automatic drain_averages();
        push <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_span(input logic [SPAN_BITS-1:0] value);
        drain_averages();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.write_span(value);
    endtask

    // mostly full range, now and then an extreme
    function automatic logic [SAMPLE_BITS-1:0] random_sample();
        case ($urandom_range(15))
            0:       return 16'h7fff;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hffff;
            default: return SAMPLE_BITS'($urandom_range(0, 65535));
        endcase
    endfunction

    // stimulus
    initial
    begin : stimulus
        int span_plan[12];
        int span;
        span_plan = '{1, 3, 8, 2, 16, 5, 0, 4, 31, 7, 2047, 12};
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_epoch         = 0;
        rst_n     <= 1'b0;
        push      <= 1'b0;
        item      <= '0;
        cfg_we    <= 1'b0;
        cfg_wdata <= SPAN_RESET;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full groups at both sample extremes, reset span
        repeat (8) send_sample(16'h7fff);
        repeat (8) send_sample(16'h8000);
        // flush of an empty group
        send_flush();
        // flush with a zero partial sum
        send_sample(16'd5);
        send_sample(-16'sd5);
        send_flush();
        // flush of a short group
        send_sample(16'd1);
        send_sample(16'h8000);
        send_sample(16'd3);
        send_flush();

        // span lowered mid-group closes the group on the next sample
        repeat (5) send_sample(random_sample());
        write_span(11'd3);
        send_sample(random_sample());

        // span of zero acts as one
        write_span(11'd0);
        send_sample(16'hffff);
        send_sample(16'h7fff);

        // oversize span holds the group open; short group at the positive extreme
        write_span(11'h7ff);
        repeat (40) send_sample(16'h7fff);
        send_flush();

        // largest span, short group at the negative extreme
        write_span(11'd1024);
        repeat (5) send_sample(16'h8000);
        send_flush();

        // random phases over spans and idle patterns
        for (int ph = 0; ph < 12; ph++)
        begin
            span = (ph == 8) ? $urandom_range(9, 64) : span_plan[ph];
            write_span(SPAN_BITS'(span));
            case (ph % 4)
                0:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct    = 52;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 52;
                end
                default:
                begin
                    sender_idle_pct    = 24;
                    receiver_stall_pct = 24;
                end
            endcase
            // one long hold-off while single-sample groups pile up
            if (ph == 0)
                hold_epoch <= hold_epoch + 1;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(99) < 7)
                    send_flush();
                else
                    send_sample(random_sample());
            end
        end

        drain_averages();
        if (board.errors == 0 && board.pending() == 0)
            $display("block_average_decimator: match");
        else
            $display("block_average_decimator: mismatch");
        $finish;
    end

endmodule
